// File: sv/aarm_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// aarm_pkg
// Shared types and constants for the axis-angle to rotation matrix block.
// -----------------------------------------------------------------------------
package aarm_pkg;

    localparam int AtanEntries = 24;
    localparam int CordicW = 34;
    localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;

    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic        [15:0] turn_angle;
    } axis_in_t;

    typedef struct packed {
        logic signed [15:0] m_xx;
        logic signed [15:0] m_xy;
        logic signed [15:0] m_xz;
        logic signed [15:0] m_yx;
        logic signed [15:0] m_yy;
        logic signed [15:0] m_yz;
        logic signed [15:0] m_zx;
        logic signed [15:0] m_zy;
        logic signed [15:0] m_zz;
    } matrix_out_t;

    typedef struct packed {
        logic signed [CordicW-1:0] x;
        logic signed [CordicW-1:0] y;
        logic signed [31:0]        z;
        logic        [1:0]         quad;
        logic signed [15:0]        ax;
        logic signed [15:0]        ay;
        logic signed [15:0]        az;
    } cordic_bus_t;

    function automatic logic signed [31:0] atan_turn(input logic [4:0] idx);
        case (idx)
            5'd0:  atan_turn = 32'h20000000;
            5'd1:  atan_turn = 32'h12E4051E;
            5'd2:  atan_turn = 32'h09FB385B;
            5'd3:  atan_turn = 32'h051111D4;
            5'd4:  atan_turn = 32'h028B0D43;
            5'd5:  atan_turn = 32'h0145D7E1;
            5'd6:  atan_turn = 32'h00A2F61E;
            5'd7:  atan_turn = 32'h00517C55;
            5'd8:  atan_turn = 32'h0028BE53;
            5'd9:  atan_turn = 32'h00145F2F;
            5'd10: atan_turn = 32'h000A2F98;
            5'd11: atan_turn = 32'h000517CC;
            5'd12: atan_turn = 32'h00028BE6;
            5'd13: atan_turn = 32'h000145F3;
            5'd14: atan_turn = 32'h0000A2FA;
            5'd15: atan_turn = 32'h0000517D;
            5'd16: atan_turn = 32'h000028BE;
            5'd17: atan_turn = 32'h0000145F;
            5'd18: atan_turn = 32'h00000A30;
            5'd19: atan_turn = 32'h00000518;
            5'd20: atan_turn = 32'h0000028C;
            5'd21: atan_turn = 32'h00000146;
            5'd22: atan_turn = 32'h000000A3;
            5'd23: atan_turn = 32'h00000051;
            default: atan_turn = 32'h0;
        endcase
    endfunction

endpackage

// File: sv/axis_angle_to_rotation_matrix_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// axis_angle_to_rotation_matrix_top
// Rodrigues rotation matrix from a Q2.14 axis and a binary angle (negated).
//
//   channel | dir | payload
//   s_      | in  | axis_in_t    (axis_x, axis_y, axis_z, turn_angle)
//   m_      | out | matrix_out_t (nine Q2.14 entries)
//
// One transaction per cycle while the pipe advances; the path is
// a chain of CORDIC cells, then four math stages, then the output register.
// The whole pipe advances when the output register is empty or taken.
// Reset clears only the valid bits.
// -----------------------------------------------------------------------------
module axis_angle_to_rotation_matrix_top #(
    parameter int TRIG_STAGES = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  aarm_pkg::axis_in_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output aarm_pkg::matrix_out_t m_data
);
    import aarm_pkg::*;

    localparam int NCells = (TRIG_STAGES < AtanEntries) ? TRIG_STAGES : AtanEntries;

    logic        en;
    cordic_bus_t bus   [NCells+1];
    logic        vld   [NCells+1];
    logic [31:0] angle;

    logic        mat_valid;
    matrix_out_t mat_data;
    logic        out_valid_reg;
    matrix_out_t out_reg;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    assign angle       = {16'(16'd0 - s_data.turn_angle), 16'd0};
    assign vld[0]      = s_valid;
    assign bus[0].x    = CordicGain;
    assign bus[0].y    = '0;
    assign bus[0].z    = {2'b00, angle[29:0]};
    assign bus[0].quad = angle[31:30];
    assign bus[0].ax   = s_data.axis_x;
    assign bus[0].ay   = s_data.axis_y;
    assign bus[0].az   = s_data.axis_z;

    for (genvar i = 0; i < NCells; i++) begin : g_cell
        aarm_cordic_cell #(.STAGE(i)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (vld[i]),
            .in_bus   (bus[i]),
            .out_valid(vld[i+1]),
            .out_bus  (bus[i+1])
        );
    end

    aarm_matrix u_matrix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (vld[NCells]),
        .in_bus   (bus[NCells]),
        .out_valid(mat_valid),
        .out_data (mat_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= mat_valid;
        end
        if (en) begin
            out_reg <= mat_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
endmodule

// File: sv/aarm_cordic_cell.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// aarm_cordic_cell
// One CORDIC rotation stage; registers its result and forwards the axis.
// -----------------------------------------------------------------------------
module aarm_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  aarm_pkg::cordic_bus_t in_bus,
    output logic                  out_valid,
    output aarm_pkg::cordic_bus_t out_bus
);
    import aarm_pkg::*;

    localparam logic signed [31:0] Atan = atan_turn(5'(STAGE));

    cordic_bus_t bus_reg, bus_next;
    logic        valid_reg;

    always_comb begin
        bus_next = in_bus;
        if (!in_bus.z[31]) begin
            bus_next.x = in_bus.x - (in_bus.y >>> STAGE);
            bus_next.y = in_bus.y + (in_bus.x >>> STAGE);
            bus_next.z = in_bus.z - Atan;
        end else begin
            bus_next.x = in_bus.x + (in_bus.y >>> STAGE);
            bus_next.y = in_bus.y - (in_bus.x >>> STAGE);
            bus_next.z = in_bus.z + Atan;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            bus_reg <= bus_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_bus   = bus_reg;
endmodule

// File: sv/aarm_matrix.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// aarm_matrix
// Quadrant fix-up, rounding to Q2.14, and the Rodrigues products.
// Four register stages: sin/cos, first products, second products, entries.
// -----------------------------------------------------------------------------
module aarm_matrix (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  aarm_pkg::cordic_bus_t in_bus,
    output logic                  out_valid,
    output aarm_pkg::matrix_out_t out_data
);
    import aarm_pkg::*;

    logic [3:0] valid_reg;

    // stage 1
    logic signed [CordicW-1:0] c_full, s_full;
    logic signed [CordicW-1:0] c_rnd, s_rnd;
    logic signed [17:0] c1_reg, s1_reg, c1_next, s1_next;
    logic signed [15:0] ax1_reg, ay1_reg, az1_reg;

    always_comb begin
        case (in_bus.quad)
            2'd0: begin c_full = in_bus.x;  s_full = in_bus.y;  end
            2'd1: begin c_full = -in_bus.y; s_full = in_bus.x;  end
            2'd2: begin c_full = -in_bus.x; s_full = -in_bus.y; end
            default: begin c_full = in_bus.y; s_full = -in_bus.x; end
        endcase
        c_rnd   = (c_full + CordicW'(32768)) >>> 16;
        s_rnd   = (s_full + CordicW'(32768)) >>> 16;
        c1_next = c_rnd[17:0];
        s1_next = s_rnd[17:0];
    end

    // stage 2: cc*a, a*s, c term
    logic signed [34:0] ccx2_reg, ccy2_reg, ccz2_reg;
    logic signed [34:0] xs2_reg, ys2_reg, zs2_reg;
    logic signed [17:0] c2_reg;
    logic signed [15:0] ax2_reg, ay2_reg, az2_reg;
    logic signed [18:0] cc1;
    assign cc1 = 19'sd16384 - 19'(c1_reg);

    // stage 3: products
    logic signed [51:0] xx3_reg, yy3_reg, zz3_reg, xy3_reg, xz3_reg, yz3_reg;
    logic signed [51:0] px3_reg, py3_reg, pz3_reg, ct3_reg;

    // stage 4: sums, round, saturate
    function automatic logic signed [15:0] finish(input logic signed [51:0] v);
        logic signed [51:0] r;
        r = (v + 52'sd134217728) >>> 28;
        if (r > 52'sd32767)       finish = 16'sh7FFF;
        else if (r < -52'sd32768) finish = 16'sh8000;
        else                      finish = r[15:0];
    endfunction

    matrix_out_t out_reg, out_next;
    always_comb begin
        out_next.m_xx = finish(xx3_reg + ct3_reg);
        out_next.m_yy = finish(yy3_reg + ct3_reg);
        out_next.m_zz = finish(zz3_reg + ct3_reg);
        out_next.m_zy = finish(yz3_reg + px3_reg);
        out_next.m_yz = finish(yz3_reg - px3_reg);
        out_next.m_xz = finish(xz3_reg + py3_reg);
        out_next.m_zx = finish(xz3_reg - py3_reg);
        out_next.m_yx = finish(xy3_reg + pz3_reg);
        out_next.m_xy = finish(xy3_reg - pz3_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
        if (en) begin
            c1_reg  <= c1_next;
            s1_reg  <= s1_next;
            ax1_reg <= in_bus.ax;
            ay1_reg <= in_bus.ay;
            az1_reg <= in_bus.az;

            ccx2_reg <= 35'(cc1) * 35'(ax1_reg);
            ccy2_reg <= 35'(cc1) * 35'(ay1_reg);
            ccz2_reg <= 35'(cc1) * 35'(az1_reg);
            xs2_reg  <= 35'(s1_reg) * 35'(ax1_reg);
            ys2_reg  <= 35'(s1_reg) * 35'(ay1_reg);
            zs2_reg  <= 35'(s1_reg) * 35'(az1_reg);
            c2_reg   <= c1_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            az2_reg  <= az1_reg;

            xx3_reg <= 52'(ccx2_reg) * 52'(ax2_reg);
            yy3_reg <= 52'(ccy2_reg) * 52'(ay2_reg);
            zz3_reg <= 52'(ccz2_reg) * 52'(az2_reg);
            xy3_reg <= 52'(ccx2_reg) * 52'(ay2_reg);
            xz3_reg <= 52'(ccx2_reg) * 52'(az2_reg);
            yz3_reg <= 52'(ccz2_reg) * 52'(ay2_reg);
            px3_reg <= 52'(xs2_reg) <<< 14;
            py3_reg <= 52'(ys2_reg) <<< 14;
            pz3_reg <= 52'(zs2_reg) <<< 14;
            ct3_reg <= 52'(c2_reg) <<< 28;

            out_reg <= out_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_data  = out_reg;
endmodule

// File: sv/aarm_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// aarm_checker
// Port-level checks for the rotation matrix block, bound to the top level.
// -----------------------------------------------------------------------------
module aarm_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input aarm_pkg::matrix_out_t m_data
);
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready) else $error("input stalled with empty output");
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready) else $error("input stalled while output taken");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("valid after reset");
endmodule

bind axis_angle_to_rotation_matrix_top aarm_checker u_aarm_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
